// ----- sv/lix_pkg.sv -----
// ----------------------------------------------------------------------------
// lix_pkg: line intersection types and constants
// Word formats, internal stage records and derived widths for the
// Cramer's-rule intersection pipeline.
// ----------------------------------------------------------------------------
package lix_pkg;

  localparam int unsigned CoordW      = 16;
  localparam int unsigned DiffW       = CoordW + 1;
  localparam int unsigned CW          = 2 * CoordW + 2;
  localparam int unsigned DetW        = 2 * CoordW + 3;
  localparam int unsigned LoW         = CoordW + 1;
  localparam int unsigned HiW         = CW - LoW;
  localparam int unsigned PHiW        = DiffW + HiW + 1;
  localparam int unsigned PLoW        = DiffW + LoW + 2;
  localparam int unsigned NumW        = 3 * CoordW + 4;
  localparam int unsigned FrontStages = 6;
  localparam int unsigned NumStages   = FrontStages + CoordW;

  localparam logic signed [CoordW-1:0] MaxCoord = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] MinCoord = {1'b1, {(CoordW-1){1'b0}}};

  typedef struct packed {
    logic signed [CoordW-1:0] point_a_x;
    logic signed [CoordW-1:0] point_a_y;
    logic signed [CoordW-1:0] point_b_x;
    logic signed [CoordW-1:0] point_b_y;
    logic signed [CoordW-1:0] point_c_x;
    logic signed [CoordW-1:0] point_c_y;
    logic signed [CoordW-1:0] point_d_x;
    logic signed [CoordW-1:0] point_d_y;
  } lix_in_t;

  typedef struct packed {
    logic                     meets;
    logic signed [CoordW-1:0] cross_x;
    logic signed [CoordW-1:0] cross_y;
    logic                     clipped;
  } lix_out_t;

  typedef struct packed {
    logic signed [DiffW-1:0]  a1;
    logic signed [DiffW-1:0]  b1;
    logic signed [DiffW-1:0]  a2;
    logic signed [DiffW-1:0]  b2;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
  } coef_t;

  typedef struct packed {
    logic signed [DiffW-1:0] a1;
    logic signed [DiffW-1:0] b1;
    logic signed [DiffW-1:0] a2;
    logic signed [DiffW-1:0] b2;
    logic signed [CW-1:0]    c1;
    logic signed [CW-1:0]    c2;
    logic signed [DetW-1:0]  det;
  } cram_t;

  typedef struct packed {
    logic signed [PHiW-1:0] xh;
    logic signed [PLoW-1:0] xl;
    logic signed [PHiW-1:0] yh;
    logic signed [PLoW-1:0] yl;
    logic signed [DetW-1:0] det;
  } part_t;

  typedef struct packed {
    logic signed [NumW-1:0] nx;
    logic signed [NumW-1:0] ny;
    logic signed [DetW-1:0] det;
  } num_t;

  typedef struct packed {
    logic [NumW-1:0] mx;
    logic [NumW-1:0] my;
    logic [DetW-1:0] md;
    logic            neg_x;
    logic            neg_y;
    logic            par;
  } mag_t;

  typedef struct packed {
    logic [NumW-1:0]   rx;
    logic [NumW-1:0]   ry;
    logic [DetW-1:0]   md;
    logic [CoordW-1:0] qx;
    logic [CoordW-1:0] qy;
    logic              neg_x;
    logic              neg_y;
    logic              ovf_x;
    logic              ovf_y;
    logic              par;
  } div_t;

endpackage

// ----- sv/lix_coef.sv -----
// ----------------------------------------------------------------------------
// lix_coef: line coefficients and products
// Three stages: point differences, c terms and determinant, then split
// partial products of both numerators.
// ----------------------------------------------------------------------------
module lix_coef import lix_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  lix_in_t in_i,
  output part_t   part_o
);

  coef_t s1_d, s1_q;
  cram_t s2_d, s2_q;
  part_t s3_d, s3_q;

  logic signed [HiW-1:0] c1_hi, c2_hi;
  logic signed [LoW:0]   c1_lo, c2_lo;

  always_comb begin
    s1_d.a1 = DiffW'($signed(in_i.point_b_y)) - DiffW'($signed(in_i.point_a_y));
    s1_d.b1 = DiffW'($signed(in_i.point_a_x)) - DiffW'($signed(in_i.point_b_x));
    s1_d.a2 = DiffW'($signed(in_i.point_d_y)) - DiffW'($signed(in_i.point_c_y));
    s1_d.b2 = DiffW'($signed(in_i.point_c_x)) - DiffW'($signed(in_i.point_d_x));
    s1_d.ax = in_i.point_a_x;
    s1_d.ay = in_i.point_a_y;
    s1_d.cx = in_i.point_c_x;
    s1_d.cy = in_i.point_c_y;
  end

  always_comb begin
    s2_d.a1  = s1_q.a1;
    s2_d.b1  = s1_q.b1;
    s2_d.a2  = s1_q.a2;
    s2_d.b2  = s1_q.b2;
    s2_d.c1  = CW'(s1_q.a1) * CW'(s1_q.ax) + CW'(s1_q.b1) * CW'(s1_q.ay);
    s2_d.c2  = CW'(s1_q.a2) * CW'(s1_q.cx) + CW'(s1_q.b2) * CW'(s1_q.cy);
    s2_d.det = DetW'(s1_q.a1) * DetW'(s1_q.b2) - DetW'(s1_q.a2) * DetW'(s1_q.b1);
  end

  // split c into a signed high half and an unsigned low half
  always_comb begin
    c1_hi = $signed(s2_q.c1[CW-1:LoW]);
    c2_hi = $signed(s2_q.c2[CW-1:LoW]);
    c1_lo = $signed({1'b0, s2_q.c1[LoW-1:0]});
    c2_lo = $signed({1'b0, s2_q.c2[LoW-1:0]});
    s3_d.xh  = PHiW'(s2_q.b2) * PHiW'(c1_hi) - PHiW'(s2_q.b1) * PHiW'(c2_hi);
    s3_d.xl  = PLoW'(s2_q.b2) * PLoW'(c1_lo) - PLoW'(s2_q.b1) * PLoW'(c2_lo);
    s3_d.yh  = PHiW'(s2_q.a1) * PHiW'(c2_hi) - PHiW'(s2_q.a2) * PHiW'(c1_hi);
    s3_d.yl  = PLoW'(s2_q.a1) * PLoW'(c2_lo) - PLoW'(s2_q.a2) * PLoW'(c1_lo);
    s3_d.det = s2_q.det;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  assign part_o = s3_q;

endmodule

// ----- sv/lix_norm.sv -----
// ----------------------------------------------------------------------------
// lix_norm: numerator assembly and divider setup
// Three stages: join partial products, take magnitudes and quotient signs,
// then flag quotients too large for the coordinate width.
// ----------------------------------------------------------------------------
module lix_norm import lix_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  part_t part_i,
  output div_t  div_o
);

  num_t s4_d, s4_q;
  mag_t s5_d, s5_q;
  div_t s6_d, s6_q;

  logic signed [NumW-1:0] xh_ext, xl_ext, yh_ext, yl_ext;
  logic        [NumW-1:0] dsh;

  always_comb begin
    xh_ext   = NumW'(part_i.xh);
    xl_ext   = NumW'(part_i.xl);
    yh_ext   = NumW'(part_i.yh);
    yl_ext   = NumW'(part_i.yl);
    s4_d.nx  = (xh_ext <<< LoW) + xl_ext;
    s4_d.ny  = (yh_ext <<< LoW) + yl_ext;
    s4_d.det = part_i.det;
  end

  always_comb begin
    s5_d.mx    = s4_q.nx[NumW-1] ? NumW'(-s4_q.nx) : NumW'(s4_q.nx);
    s5_d.my    = s4_q.ny[NumW-1] ? NumW'(-s4_q.ny) : NumW'(s4_q.ny);
    s5_d.md    = s4_q.det[DetW-1] ? DetW'(-s4_q.det) : DetW'(s4_q.det);
    s5_d.neg_x = s4_q.nx[NumW-1] ^ s4_q.det[DetW-1];
    s5_d.neg_y = s4_q.ny[NumW-1] ^ s4_q.det[DetW-1];
    s5_d.par   = (s4_q.det == '0);
  end

  always_comb begin
    dsh        = NumW'(s5_q.md) << CoordW;
    s6_d.rx    = s5_q.mx;
    s6_d.ry    = s5_q.my;
    s6_d.md    = s5_q.md;
    s6_d.qx    = '0;
    s6_d.qy    = '0;
    s6_d.neg_x = s5_q.neg_x;
    s6_d.neg_y = s5_q.neg_y;
    s6_d.ovf_x = (s5_q.mx >= dsh);
    s6_d.ovf_y = (s5_q.my >= dsh);
    s6_d.par   = s5_q.par;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_q <= s4_d;
      s5_q <= s5_d;
      s6_q <= s6_d;
    end
  end

  assign div_o = s6_q;

endmodule

// ----- sv/lix_div_step.sv -----
// ----------------------------------------------------------------------------
// lix_div_step: one restoring division stage
// Resolves one quotient bit of each coordinate, then shifts the remainder.
// ----------------------------------------------------------------------------
module lix_div_step import lix_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t div_i,
  output div_t div_o
);

  div_t            step_d, step_q;
  logic [NumW-1:0] dsh, rx_n, ry_n;
  logic            bit_x, bit_y;

  always_comb begin
    dsh    = NumW'(div_i.md) << (CoordW - 1);
    bit_x  = (div_i.rx >= dsh);
    bit_y  = (div_i.ry >= dsh);
    rx_n   = bit_x ? div_i.rx - dsh : div_i.rx;
    ry_n   = bit_y ? div_i.ry - dsh : div_i.ry;
    step_d = div_i;
    step_d.rx = rx_n << 1;
    step_d.ry = ry_n << 1;
    step_d.qx = {div_i.qx[CoordW-2:0], bit_x};
    step_d.qy = {div_i.qy[CoordW-2:0], bit_y};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign div_o = step_q;

endmodule

// ----- sv/lix_out.sv -----
// ----------------------------------------------------------------------------
// lix_out: saturation and output queue
// Applies sign and range limits to the quotients and holds results in a
// two-entry queue; a full queue freezes the pipeline.
// ----------------------------------------------------------------------------
module lix_out import lix_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     vld_i,
  input  div_t     div_i,
  output logic     en_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lix_out_t out_word_o
);

  localparam logic [CoordW-1:0] HalfRange = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [1:0]        QueueFull = 2'd2;

  lix_out_t   res;
  lix_out_t   slot0_d, slot0_q, slot1_d, slot1_q;
  logic [1:0] cnt_d, cnt_q;
  logic       push, pop;
  logic [CoordW:0] sat_x, sat_y;

  // returns {clip, value}
  function automatic logic [CoordW:0] sat(input logic [CoordW-1:0] q,
                                          input logic neg, input logic ovf);
    logic [CoordW:0] r;
    if (ovf) begin
      r = {1'b1, neg ? MinCoord : MaxCoord};
    end else if (neg) begin
      if (q > HalfRange) begin
        r = {1'b1, MinCoord};
      end else begin
        r = {1'b0, CoordW'(-q)};
      end
    end else if (q[CoordW-1]) begin
      r = {1'b1, MaxCoord};
    end else begin
      r = {1'b0, q};
    end
    return r;
  endfunction

  always_comb begin
    sat_x = sat(div_i.qx, div_i.neg_x, div_i.ovf_x);
    sat_y = sat(div_i.qy, div_i.neg_y, div_i.ovf_y);
    if (div_i.par) begin
      res.meets   = 1'b0;
      res.cross_x = MaxCoord;
      res.cross_y = MaxCoord;
      res.clipped = 1'b0;
    end else begin
      res.meets   = 1'b1;
      res.cross_x = sat_x[CoordW-1:0];
      res.cross_y = sat_y[CoordW-1:0];
      res.clipped = sat_x[CoordW] | sat_y[CoordW];
    end
  end

  assign en_o        = (cnt_q != QueueFull);
  assign out_valid_o = (cnt_q != 2'd0);
  assign push        = vld_i & en_o;
  assign pop         = out_valid_o & ~out_stall_i;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    case ({push, pop})
      2'b10: begin
        if (cnt_q == 2'd0) begin
          slot0_d = res;
        end else begin
          slot1_d = res;
        end
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        slot0_d = slot1_q;
        cnt_d   = cnt_q - 2'd1;
      end
      2'b11: begin
        slot0_d = res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign out_word_o = slot0_q;

endmodule

// ----- sv/line_intersection.sv -----
// ----------------------------------------------------------------------------
// line_intersection: two-line intersection by Cramer's rule
// Input word: points A, B, C, D in signed fixed point. Output word: meets
// flag, intersection x and y, and a saturation flag.
// ----------------------------------------------------------------------------
// Usage
//   Both channels carry one word per handshake; a word moves on a rising
//   edge where valid is high and stall is low.
//   Throughput: one word per cycle while the output queue is not full.
//   Pipeline: 6 arithmetic stages followed by 16 divider stages (one
//   quotient bit each), then a two-entry output queue.
//   Parallel or degenerate lines give meets low and both coordinates at the
//   largest positive value; out-of-range quotients saturate with clipped.
//   Receiver stall: the head word holds on out_word_o; the queue absorbs one
//   more word, and when it is full in_stall_o rises and every stage holds.
//   Reset clears all stage valid bits and empties the queue; in_stall_o is
//   low right after reset.
// ----------------------------------------------------------------------------
module line_intersection import lix_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lix_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lix_out_t out_word_o
);

  logic                 en;
  logic [NumStages-1:0] vld_q;
  part_t                part;
  div_t                 div_chain [CoordW+1];

  assign in_stall_o = ~en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  lix_coef u_coef (
    .clk_i  (clk_i),
    .en_i   (en),
    .in_i   (in_word_i),
    .part_o (part)
  );

  lix_norm u_norm (
    .clk_i  (clk_i),
    .en_i   (en),
    .part_i (part),
    .div_o  (div_chain[0])
  );

  for (genvar i = 0; i < CoordW; i++) begin : g_div
    lix_div_step u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .div_i (div_chain[i]),
      .div_o (div_chain[i+1])
    );
  end

  lix_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (vld_q[NumStages-1]),
    .div_i       (div_chain[CoordW]),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTH
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline advanced while input stalled");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output queue");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("output word dropped without handshake");

  a_par: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.meets) |->
      (out_word_o.cross_x == MaxCoord && out_word_o.cross_y == MaxCoord &&
       !out_word_o.clipped))
    else $error("parallel result not at limit value");
`endif

endmodule

// ----- test/line_intersection_compare.sv -----
// ----------------------------------------------------------------------------
// line_intersection_compare: result predictor and comparator
// Watches both channels of line_intersection. Every accepted input word is
// turned into its expected crossing by exact wide Cramer's-rule arithmetic;
// every accepted output word is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module line_intersection_compare import lix_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  lix_in_t  in_word_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  lix_out_t out_word_i,
  output int       pending_o,
  output int       mismatches_o
);

  lix_out_t crossings_due[$];

  initial begin
    pending_o    = 0;
    mismatches_o = 0;
  end

  function automatic lix_out_t predict_crossing(lix_in_t w);
    logic signed [127:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic signed [127:0] a1, b1, a2, b2, c1, c2, det, qx, qy, hi_lim, lo_lim;
    lix_out_t r;
    hi_lim = 128'(MaxCoord);
    lo_lim = 128'(MinCoord);
    ax = 128'(w.point_a_x);
    ay = 128'(w.point_a_y);
    bx = 128'(w.point_b_x);
    by = 128'(w.point_b_y);
    cx = 128'(w.point_c_x);
    cy = 128'(w.point_c_y);
    dx = 128'(w.point_d_x);
    dy = 128'(w.point_d_y);
    a1 = by - ay;
    b1 = ax - bx;
    a2 = dy - cy;
    b2 = cx - dx;
    c1 = a1 * ax + b1 * ay;
    c2 = a2 * cx + b2 * cy;
    det = a1 * b2 - a2 * b1;
    r.clipped = 1'b0;
    if (det == '0) begin
      r.meets   = 1'b0;
      r.cross_x = MaxCoord;
      r.cross_y = MaxCoord;
    end else begin
      qx = (b2 * c1 - b1 * c2) / det;
      qy = (a1 * c2 - a2 * c1) / det;
      r.meets = 1'b1;
      if (qx > hi_lim) begin
        qx = hi_lim;
        r.clipped = 1'b1;
      end else if (qx < lo_lim) begin
        qx = lo_lim;
        r.clipped = 1'b1;
      end
      if (qy > hi_lim) begin
        qy = hi_lim;
        r.clipped = 1'b1;
      end else if (qy < lo_lim) begin
        qy = lo_lim;
        r.clipped = 1'b1;
      end
      r.cross_x = qx[CoordW-1:0];
      r.cross_y = qy[CoordW-1:0];
    end
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  always @(posedge clk_i) begin : watch
    lix_out_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (crossings_due.size() == 0) begin
          flag_mismatch("output word with nothing expected");
        end else begin
          want = crossings_due.pop_front();
          if (out_word_i.meets !== want.meets)
            flag_mismatch($sformatf("meets got %b expected %b",
                                    out_word_i.meets, want.meets));
          if (out_word_i.cross_x !== want.cross_x)
            flag_mismatch($sformatf("cross_x got %0d expected %0d",
                                    out_word_i.cross_x, want.cross_x));
          if (out_word_i.cross_y !== want.cross_y)
            flag_mismatch($sformatf("cross_y got %0d expected %0d",
                                    out_word_i.cross_y, want.cross_y));
          if (out_word_i.clipped !== want.clipped)
            flag_mismatch($sformatf("clipped got %b expected %b",
                                    out_word_i.clipped, want.clipped));
        end
      end
      if (in_valid_i && !in_stall_i)
        crossings_due = {crossings_due, predict_crossing(in_word_i)};
      pending_o <= crossings_due.size();
    end
  end

endmodule

// ----- test/line_intersection_test.sv -----
// ----------------------------------------------------------------------------
// line_intersection_test: stimulus and verdict for line_intersection
// Sends directed corner cases (degenerate, parallel, collinear, saturating
// and truncating crossings, field extremes), then random words in phases of
// sender gaps and receiver stalls; line_intersection_compare checks results.
// ----------------------------------------------------------------------------
module line_intersection_test;
  import lix_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int DrainCycles  = 40;
  localparam int PhaseWords   = 412;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall;
  lix_in_t  in_word;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lix_out_t out_word;

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int cycle_count     = 0;
  int pending;
  int mismatches;

  line_intersection dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  line_intersection_compare u_compare (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  always @(posedge clk_i) out_stall <= rst_ni && ($urandom_range(99) < stall_pct);

  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("line_intersection test failed");
    $finish;
  end

  function automatic lix_in_t make_word(int ax, int ay, int bx, int by,
                                        int cx, int cy, int dx, int dy);
    lix_in_t w;
    w.point_a_x = ax[CoordW-1:0];
    w.point_a_y = ay[CoordW-1:0];
    w.point_b_x = bx[CoordW-1:0];
    w.point_b_y = by[CoordW-1:0];
    w.point_c_x = cx[CoordW-1:0];
    w.point_c_y = cy[CoordW-1:0];
    w.point_d_x = dx[CoordW-1:0];
    w.point_d_y = dy[CoordW-1:0];
    return w;
  endfunction

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int corner();
    int picks[6] = '{-32768, -32767, -1, 0, 1, 32767};
    return picks[3'($urandom_range(5))];
  endfunction

  function automatic lix_in_t random_word();
    int kind, ax, ay, bx, by, cx, cy, dx, dy, ux, uy, k;
    kind = $urandom_range(99);
    if (kind < 30) return lix_in_t'({$urandom, $urandom, $urandom, $urandom});
    if (kind >= 92)
      return make_word(corner(), corner(), corner(), corner(),
                       corner(), corner(), corner(), corner());
    ax = span(-8000, 8000);
    ay = span(-8000, 8000);
    cx = span(-8000, 8000);
    cy = span(-8000, 8000);
    if (kind < 55) begin
      bx = span(-2048, 2048);
      by = span(-2048, 2048);
      dx = span(-2048, 2048);
      dy = span(-2048, 2048);
      ax = ax / 4;
      ay = ay / 4;
      cx = cx / 4;
      cy = cy / 4;
    end else if (kind < 70) begin
      // parallel: line two runs along a multiple of line one's direction
      ux = span(-3000, 3000);
      uy = span(-3000, 3000);
      k  = span(-3, 3);
      bx = ax + ux;
      by = ay + uy;
      dx = cx + k * ux;
      dy = cy + k * uy;
    end else if (kind < 78) begin
      bx = span(-8000, 8000);
      by = span(-8000, 8000);
      dx = span(-8000, 8000);
      dy = span(-8000, 8000);
      if ($urandom_range(1)) begin
        bx = ax;
        by = ay;
      end else begin
        dx = cx;
        dy = cy;
      end
    end else begin
      // nearly parallel: far crossings that tend to saturate
      ux = span(-8000, 8000);
      uy = span(-8000, 8000);
      bx = ax + ux;
      by = ay + uy;
      dx = cx + ux + span(-3, 3);
      dy = cy + uy + span(-3, 3);
    end
    return make_word(ax, ay, bx, by, cx, cy, dx, dy);
  endfunction

  task automatic send_word(lix_in_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
  endtask

  initial begin : stimulus
    lix_in_t directed[$];
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = {
      make_word(0, 0, 0, 0, 0, 0, 0, 0),
      make_word(0, 0, 256, 256, 0, 256, 256, 0),
      make_word(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768),
      make_word(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767),
      make_word(0, 0, 256, 0, 0, 256, 256, 256),
      make_word(-32768, 0, -32768, 256, 32767, -32768, 32767, 32767),
      make_word(100, 100, 100, 100, 0, 0, 256, 512),
      make_word(0, 0, 256, 512, -32768, 32767, -32768, 32767),
      make_word(0, 0, 256, 0, -32768, 2, 32767, 1),
      make_word(0, 0, 256, 0, -32768, 1, 32767, 2),
      make_word(0, 0, 0, 256, 2, -32768, 1, 32767),
      make_word(0, 0, 0, 256, 1, -32768, 2, 32767),
      make_word(-32768, 0, -32768, 256, 0, 0, 256, 0),
      make_word(32767, 0, 32767, 256, 0, 5, 256, 5),
      make_word(0, -32768, 256, -32768, 7, 0, 7, 256),
      make_word(0, 0, 3, 2, 0, -1, 5, -1),
      make_word(0, 0, 3, 2, 0, 1, 5, 1),
      make_word(0, 0, 2, 3, -1, 0, -1, 5),
      make_word(0, 0, 256, 256, 512, 512, -256, -256),
      make_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
      make_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
      lix_in_t'({4{32'h5555aaaa}}),
      lix_in_t'({4{32'haaaa5555}}),
      make_word(-1, 1, 1, -1, 1, 1, -1, -1)
    };
    foreach (directed[i]) send_word(directed[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          stall_pct       = 0;
        end
        1: begin
          sender_idle_pct = 73;
          stall_pct       = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct       = 73;
        end
        default: begin
          sender_idle_pct = 10;
          stall_pct       = 10;
        end
      endcase
      repeat (PhaseWords) send_word(random_word());
      if (phase == 1) begin
        // hold off until the pipeline is empty
        in_valid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("line_intersection test passed");
    end else begin
      $display("line_intersection test failed");
    end
    $finish;
  end

endmodule
